// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the match finder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every clock edge out of reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/lzmf_pkg.sv =====
// Package of constants and types for the lazy match finder.
`default_nettype none
package lzmf_pkg;
  localparam int WINDOW_SIZE = 2048;
  localparam int MAX_MATCH   = 258;
  localparam int RING_DEPTH  = 4096;
  localparam int MIN_MATCH   = 3;
  localparam int NUM_CELLS   = 8;
  localparam int LOOKAHEAD   = MAX_MATCH + 2;

  localparam int ADDR_W = 12;
  localparam int PEND_W = 9;
  localparam int HIST_W = 12;
  localparam int LEN_W  = 9;
  localparam int DIST_W = 12;
  localparam int J_W    = 9;
  localparam int GAIN_W = 9;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic       clr;
    logic       step;
    logic       cmp;
    logic [7:0] cur_byte;
  } cell_ctrl_t;
endpackage
`default_nettype wire

// ===== rtl/lz_lazy_match_finder_unit.sv =====
// Top level of the LZSS lazy match finder: control sequencer, byte ring and cell row.
// A push that leaves the lookahead short of 260 bytes is only stored; a drain on an empty
// lookahead emits the done word. A deciding item runs one or two searches of G groups of
// eight distances (G = ceil(h/8), h the reachable history up to 2048), each streaming L bytes
// (L the match limit up to 258) through the row of eight compare cells, then emits a match or
// literal word. One item is in flight at a time. Reset: rst_n, synchronous, active low.
`default_nettype none
module lz_lazy_match_finder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] literal_byte, [16:8] match_length,
                                       // [28:17] match_distance, [31:29] zero
  output logic             out_tuser,  // [0] is_match
  output logic             out_tlast,  // stream_done
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data    // lazy_gain
);
  import lzmf_pkg::*;

  `include "assert_macros.svh"

  // The sequencer: a search pass streams bytes through the cell row (FILL), lets the
  // last read land (FLUSH), then folds the cell lengths (EVAL) and moves to the next
  // group of eight distances or ends the search.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SINIT = 8'b0000_0010,
    S_FILL  = 8'b0000_0100,
    S_FLUSH = 8'b0000_1000,
    S_EVAL  = 8'b0001_0000,
    S_LIT   = 8'b0010_0000,
    S_LITW  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   ring_wr_r, ring_wr_nxt;
  logic [PEND_W-1:0]   pend_r, pend_nxt;
  logic [HIST_W-1:0]   hist_r, hist_nxt;
  logic                defer_r, defer_nxt;
  logic                drain_r, drain_nxt;
  logic [GAIN_W-1:0]   gain_r, gain_nxt;
  logic                pass_r, pass_nxt;
  logic [LEN_W-1:0]    lim_r, lim_nxt;
  logic [HIST_W-1:0]   h_r, h_nxt;
  logic [ADDR_W-1:0]   sbase_r, sbase_nxt;
  logic [DIST_W-1:0]   d0_r, d0_nxt;
  logic [J_W-1:0]      j_r, j_nxt;
  logic [LEN_W-1:0]    best_len_r, best_len_nxt;
  logic [DIST_W-1:0]   best_dist_r, best_dist_nxt;
  logic [LEN_W-1:0]    len0_r, len0_nxt;
  logic [DIST_W-1:0]   dist0_r, dist0_nxt;
  logic                pv_r, pv_nxt;
  logic                pc_r, pc_nxt;
  logic                res_match_r, res_match_nxt;
  logic [7:0]          res_lit_r, res_lit_nxt;
  logic [LEN_W-1:0]    res_len_r, res_len_nxt;
  logic [DIST_W-1:0]   res_dist_r, res_dist_nxt;
  logic                res_done_r, res_done_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_data_r, out_data_nxt;
  logic                out_user_r, out_user_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_acc;
  logic [ADDR_W-1:0]   base0;
  logic [ADDR_W-1:0]   rd_addr_a, rd_addr_b;
  logic [7:0]          rd_data_a, rd_data_b;
  logic                ram_we;
  cell_ctrl_t          cell_ctrl;
  logic [NUM_CELLS-1:0] cell_en;
  logic [7:0]          chain [NUM_CELLS+1];
  logic [LEN_W-1:0]    cell_len [NUM_CELLS];
  logic [LEN_W-1:0]    fold_len;
  logic [DIST_W-1:0]   fold_dist;
  logic                srch_done;
  logic [LEN_W-1:0]    srch_len;
  logic [DIST_W-1:0]   srch_dist;
  logic                take;
  logic [LEN_W-1:0]    take_len;
  logic [DIST_W-1:0]   take_dist;
  logic [PEND_W-1:0]   off_pend;
  logic [HIST_W:0]     hsum;
  logic [HIST_W:0]     csum;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Oldest pending byte sits this far behind the write index.
  assign base0  = ring_wr_r - ADDR_W'(pend_r);
  assign ram_we = in_acc && (in_tuser == OP_PUSH) && !drain_r;

  // Compare byte: the lookahead byte at offset j-7; window byte: j-7 before it by d0.
  always_comb begin
    rd_addr_a = sbase_r + ADDR_W'(j_r) - ADDR_W'(NUM_CELLS - 1);
    rd_addr_b = sbase_r - ADDR_W'(d0_r) - ADDR_W'(NUM_CELLS - 1) + ADDR_W'(j_r);
    if (state_r == S_LIT) begin
      rd_addr_a = base0;
    end
  end

  lzmf_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (ring_wr_r),
    .wr_data   (in_tdata),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_data_b)
  );

  // Cells are cleared on the first issue cycle of a group, before any read data lands.
  always_comb begin
    cell_ctrl.clr      = (state_r == S_FILL) && (j_r == '0);
    cell_ctrl.step     = pv_r;
    cell_ctrl.cmp      = pc_r;
    cell_ctrl.cur_byte = rd_data_a;
    for (int i = 0; i < NUM_CELLS; i++) begin
      cell_en[i] = (d0_r + DIST_W'(i)) <= h_r;
    end
  end

  assign chain[0] = rd_data_b;

  // The window byte walks down the row one cell per step, so cell i sees it i steps
  // later and thus compares against distance d0+i.
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    lzmf_cell u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .en      (cell_en[g]),
      .win_in  (chain[g]),
      .win_out (chain[g+1]),
      .len_out (cell_len[g])
    );
  end

  // Fold the group into the running best; equal lengths move to the farther distance.
  always_comb begin
    fold_len  = best_len_r;
    fold_dist = best_dist_r;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (cell_len[i] >= LEN_W'(MIN_MATCH) && cell_len[i] >= fold_len) begin
        fold_len  = cell_len[i];
        fold_dist = d0_r + DIST_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ring_wr_nxt   = ring_wr_r;
    pend_nxt      = pend_r;
    hist_nxt      = hist_r;
    defer_nxt     = defer_r;
    drain_nxt     = drain_r;
    gain_nxt      = gain_r;
    pass_nxt      = pass_r;
    lim_nxt       = lim_r;
    h_nxt         = h_r;
    sbase_nxt     = sbase_r;
    d0_nxt        = d0_r;
    j_nxt         = j_r;
    best_len_nxt  = best_len_r;
    best_dist_nxt = best_dist_r;
    len0_nxt      = len0_r;
    dist0_nxt     = dist0_r;
    pv_nxt        = (state_r == S_FILL);
    pc_nxt        = (state_r == S_FILL) && (j_r >= J_W'(NUM_CELLS - 1));
    res_match_nxt = res_match_r;
    res_lit_nxt   = res_lit_r;
    res_len_nxt   = res_len_r;
    res_dist_nxt  = res_dist_r;
    res_done_nxt  = res_done_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    srch_done     = 1'b0;
    srch_len      = '0;
    srch_dist     = '0;
    take          = 1'b0;
    take_len      = '0;
    take_dist     = '0;
    off_pend      = pend_r - PEND_W'(pass_r);
    hsum          = {1'b0, hist_r} + (HIST_W+1)'(pass_r);
    csum          = '0;

    if (cfg_valid) begin
      gain_nxt = cfg_data;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_PUSH) begin
            if (!drain_r) begin
              ring_wr_nxt = ring_wr_r + ADDR_W'(1);
              pend_nxt    = pend_r + PEND_W'(1);
              pass_nxt    = 1'b0;
              if (pend_r == PEND_W'(LOOKAHEAD - 1)) begin
                state_nxt = S_SINIT;
              end
            end
          end else if (pend_r == '0) begin
            res_match_nxt = 1'b0;
            res_lit_nxt   = '0;
            res_len_nxt   = '0;
            res_dist_nxt  = '0;
            res_done_nxt  = 1'b1;
            hist_nxt      = '0;
            defer_nxt     = 1'b0;
            drain_nxt     = 1'b0;
            state_nxt     = S_EMIT;
          end else begin
            drain_nxt = 1'b1;
            pass_nxt  = 1'b0;
            state_nxt = S_SINIT;
          end
        end
      end
      S_SINIT: begin
        lim_nxt       = (off_pend > PEND_W'(MAX_MATCH)) ? LEN_W'(MAX_MATCH) : LEN_W'(off_pend);
        h_nxt         = (hsum > (HIST_W+1)'(WINDOW_SIZE)) ? HIST_W'(WINDOW_SIZE)
                                                          : hsum[HIST_W-1:0];
        sbase_nxt     = base0 + ADDR_W'(pass_r);
        d0_nxt        = DIST_W'(1);
        j_nxt         = '0;
        best_len_nxt  = '0;
        best_dist_nxt = '0;
        if (hsum == '0) begin
          srch_done = 1'b1;
        end else begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        j_nxt = j_r + J_W'(1);
        if (j_r == J_W'(lim_r) + J_W'(NUM_CELLS - 2)) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        best_len_nxt  = fold_len;
        best_dist_nxt = fold_dist;
        d0_nxt        = d0_r + DIST_W'(NUM_CELLS);
        j_nxt         = '0;
        if ((d0_r + DIST_W'(NUM_CELLS)) > h_r) begin
          srch_done = 1'b1;
          srch_len  = fold_len;
          srch_dist = fold_dist;
        end else begin
          state_nxt = S_FILL;
        end
      end
      S_LIT: begin
        state_nxt = S_LITW;
      end
      S_LITW: begin
        res_match_nxt = 1'b0;
        res_lit_nxt   = rd_data_a;
        res_len_nxt   = '0;
        res_dist_nxt  = '0;
        res_done_nxt  = 1'b0;
        pend_nxt      = pend_r - PEND_W'(1);
        csum          = {1'b0, hist_r} + (HIST_W+1)'(1);
        hist_nxt      = (csum > (HIST_W+1)'(WINDOW_SIZE)) ? HIST_W'(WINDOW_SIZE)
                                                          : csum[HIST_W-1:0];
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, res_dist_r, res_len_r, res_lit_r};
          out_user_nxt  = res_match_r;
          out_last_nxt  = res_done_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Lazy decision once a search pass has finished.
    if (srch_done) begin
      if (!pass_r) begin
        len0_nxt  = srch_len;
        dist0_nxt = srch_dist;
        if (defer_r) begin
          defer_nxt = 1'b0;
          take      = 1'b1;
          take_len  = srch_len;
          take_dist = srch_dist;
        end else if (srch_dist != '0 && pend_r > PEND_W'(1)) begin
          pass_nxt  = 1'b1;
          state_nxt = S_SINIT;
        end else begin
          take      = 1'b1;
          take_len  = srch_len;
          take_dist = srch_dist;
        end
      end else begin
        take = 1'b1;
        if (srch_dist != '0 &&
            {1'b0, srch_len} > ({1'b0, len0_r} + {1'b0, gain_r})) begin
          defer_nxt = 1'b1;
        end else begin
          take_len  = len0_r;
          take_dist = dist0_r;
        end
      end
    end

    if (take) begin
      if (take_dist != '0) begin
        res_match_nxt = 1'b1;
        res_lit_nxt   = '0;
        res_len_nxt   = take_len;
        res_dist_nxt  = take_dist;
        res_done_nxt  = 1'b0;
        pend_nxt      = pend_r - PEND_W'(take_len);
        csum          = {1'b0, hist_r} + (HIST_W+1)'(take_len);
        hist_nxt      = (csum > (HIST_W+1)'(WINDOW_SIZE)) ? HIST_W'(WINDOW_SIZE)
                                                          : csum[HIST_W-1:0];
        state_nxt     = S_EMIT;
      end else begin
        state_nxt = S_LIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ring_wr_r   <= '0;
      pend_r      <= '0;
      hist_r      <= '0;
      defer_r     <= 1'b0;
      drain_r     <= 1'b0;
      gain_r      <= GAIN_W'(1);
      pass_r      <= 1'b0;
      pv_r        <= 1'b0;
      pc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ring_wr_r   <= ring_wr_nxt;
      pend_r      <= pend_nxt;
      hist_r      <= hist_nxt;
      defer_r     <= defer_nxt;
      drain_r     <= drain_nxt;
      gain_r      <= gain_nxt;
      pass_r      <= pass_nxt;
      pv_r        <= pv_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r       <= lim_nxt;
    h_r         <= h_nxt;
    sbase_r     <= sbase_nxt;
    d0_r        <= d0_nxt;
    j_r         <= j_nxt;
    best_len_r  <= best_len_nxt;
    best_dist_r <= best_dist_nxt;
    len0_r      <= len0_nxt;
    dist0_r     <= dist0_nxt;
    res_match_r <= res_match_nxt;
    res_lit_r   <= res_lit_nxt;
    res_len_r   <= res_len_nxt;
    res_dist_r  <= res_dist_nxt;
    res_done_r  <= res_done_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // The lookahead never holds more than one full decision's worth of bytes.
  `ASSERT_ALWAYS(a_pend_bound, pend_r <= PEND_W'(LOOKAHEAD), "lookahead count overflow")
  // Coded history saturates at the window size.
  `ASSERT_ALWAYS(a_hist_bound, hist_r <= HIST_W'(WINDOW_SIZE), "history count overflow")
  // A match token carries a legal length and distance.
  `ASSERT_IMPLY(a_match_legal, out_valid_r && out_user_r,
    out_data_r[16:8] >= 9'd3 && out_data_r[16:8] <= 9'd258 &&
    out_data_r[28:17] != 12'd0 && out_data_r[28:17] <= 12'd2048, "illegal match token")
endmodule
`default_nettype wire

// ===== rtl/lzmf_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`default_nettype none
module lzmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic      [WIDTH-1:0]         rd_data_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end
endmodule
`default_nettype wire

// ===== rtl/lzmf_cell.sv =====
// One compare cell: holds a window byte tap and the run length for one distance.
`default_nettype none
module lzmf_cell (
  input  wire logic                      clk,
  input  wire lzmf_pkg::cell_ctrl_t      ctrl,
  input  wire logic                      en,
  input  wire logic [7:0]                win_in,
  output logic      [7:0]                win_out,
  output logic      [lzmf_pkg::LEN_W-1:0] len_out
);
  import lzmf_pkg::*;

  logic [7:0]       tap_r;
  logic             alive_r;
  logic [LEN_W-1:0] len_r;

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      alive_r <= en;
      len_r   <= '0;
    end else if (ctrl.step) begin
      tap_r <= win_in;
      if (ctrl.cmp && alive_r) begin
        if (win_in == ctrl.cur_byte) begin
          len_r <= len_r + LEN_W'(1);
        end else begin
          alive_r <= 1'b0;
        end
      end
    end
  end

  assign win_out = tap_r;
  assign len_out = len_r;
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for the LZSS lazy match finder: token stream checked against a predictor.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lzmf_pkg::*;

  // One input word as the bench keeps it before driving it.
  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } byte_cmd_t;

  // One token as the block presents it on the result channel.
  typedef struct packed {
    logic        is_match;
    logic [7:0]  lit;
    logic [8:0]  len;
    logic [11:0] mdist;
    logic        done;
  } token_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [8:0] cfg_data = '0;

  // Words waiting to be offered, and tokens still owed by the block.
  byte_cmd_t cmd_q[$];
  token_t    token_q[$];

  // Shadow copy of the block's state, kept in step with every accepted word.
  logic [7:0]  ring_mem [RING_DEPTH];
  int unsigned hist_cnt;
  int unsigned pend_cnt;
  int unsigned wr_ptr;
  logic        defer_next;
  logic        in_drain;
  int unsigned gain;

  int unsigned words_taken = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          failed = 1'b0;

  always #1 clk = ~clk;

  lz_lazy_match_finder_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Longest back-reference for the lookahead byte at offset off. Farther distances win ties,
  // so the scan runs upwards and takes >= on the length.
  task automatic longest_match(input int unsigned off, output int unsigned mdist,
                               output int unsigned len);
    int unsigned limit;
    int unsigned reach;
    int unsigned start;
    int unsigned k;
    limit = pend_cnt - off;
    if (limit > MAX_MATCH) limit = MAX_MATCH;
    reach = hist_cnt + off;
    if (reach > WINDOW_SIZE) reach = WINDOW_SIZE;
    start = (wr_ptr + RING_DEPTH - pend_cnt + off) % RING_DEPTH;
    mdist = 0;
    len = 0;
    for (int unsigned d = 1; d <= reach; d++) begin
      for (k = 0; k < limit; k++) begin
        if (ring_mem[(start + k) % RING_DEPTH] !=
            ring_mem[(start + k + RING_DEPTH - d) % RING_DEPTH]) break;
      end
      if (k >= MIN_MATCH && k >= len) begin
        len = k;
        mdist = d;
      end
    end
  endtask

  // Moves n bytes from the lookahead into the history, which saturates at the window size.
  task automatic retire_bytes(input int unsigned n);
    pend_cnt -= n;
    hist_cnt += n;
    if (hist_cnt > WINDOW_SIZE) hist_cnt = WINDOW_SIZE;
  endtask

  // Token for the oldest pending byte, with the one-step lazy rule applied.
  task automatic next_token(output token_t tok);
    int unsigned mdist, len, ndist, nlen;
    int unsigned oldest;
    oldest = (wr_ptr + RING_DEPTH - pend_cnt) % RING_DEPTH;
    longest_match(0, mdist, len);
    if (defer_next) begin
      // The previous step gave up its match, so this one must take its own.
      defer_next = 1'b0;
    end else if (mdist != 0 && pend_cnt > 1) begin
      longest_match(1, ndist, nlen);
      if (ndist != 0 && nlen > len + gain) begin
        mdist = 0;
        len = 0;
        defer_next = 1'b1;
      end
    end
    tok = '0;
    if (mdist != 0) begin
      tok.is_match = 1'b1;
      tok.len = len[8:0];
      tok.mdist = mdist[11:0];
      retire_bytes(len);
    end else begin
      tok.lit = ring_mem[oldest];
      retire_bytes(1);
    end
  endtask

  // Applies one accepted word to the shadow state and queues the token it causes, if any.
  task automatic predict_word(input byte_cmd_t cmd);
    token_t tok;
    tok = '0;
    if (cmd.op == OP_PUSH) begin
      // Once the stream has ended, pushes are dropped until the done token.
      if (in_drain) return;
      ring_mem[wr_ptr] = cmd.data;
      wr_ptr = (wr_ptr + 1) % RING_DEPTH;
      pend_cnt++;
      if (pend_cnt >= LOOKAHEAD) begin
        next_token(tok);
        token_q.push_back(tok);
      end
    end else if (pend_cnt == 0) begin
      // Nothing left: report end of stream and get ready for a fresh one.
      tok.done = 1'b1;
      hist_cnt = 0;
      defer_next = 1'b0;
      in_drain = 1'b0;
      token_q.push_back(tok);
    end else begin
      in_drain = 1'b1;
      next_token(tok);
      token_q.push_back(tok);
    end
  endtask

  // Idling profile follows the number of words already taken by the block.
  always_comb begin
    if (words_taken < 220) begin
      send_idle_pct = 10;
      recv_stall_pct = 85;
    end else if (words_taken < 440) begin
      send_idle_pct = 85;
      recv_stall_pct = 10;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
  end

  // Sender: a word on offer stays put until taken; the prediction is made at the handshake.
  always @(posedge clk) begin
    byte_cmd_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        predict_word('{op: in_tuser, data: in_tdata});
        words_taken <= words_taken + 1;
      end
      if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = cmd_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= nxt.op;
        in_tdata <= nxt.data;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, and every token taken is checked against the oldest owed.
  always @(posedge clk) begin
    token_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{is_match: out_tuser, lit: out_tdata[7:0], len: out_tdata[16:8],
                mdist: out_tdata[28:17], done: out_tlast};
        if (token_q.size() == 0) begin
          $display("%0t: unexpected token, got %p", $time, got);
          failed = 1'b1;
        end else begin
          want = token_q.pop_front();
          if (got.is_match !== want.is_match || got.lit !== want.lit ||
              got.len !== want.len || got.mdist !== want.mdist || got.done !== want.done ||
              out_tdata[31:29] !== 3'b000) begin
            $display("%0t: token mismatch, expected %p, got %p", $time, want, got);
            failed = 1'b1;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Blocks until every queued word has gone in and every owed token has come out.
  task automatic wait_quiet();
    while (cmd_q.size() > 0 || in_tvalid || token_q.size() > 0) @(posedge clk);
    // Words that cause no token are not waited for above; let them settle.
    repeat (20) @(posedge clk);
  endtask

  // Writes lazy_gain while the block is idle and mirrors it in the shadow state.
  task automatic write_gain(input logic [8:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    gain = value;
    cfg_valid <= 1'b0;
  endtask

  // One stream: n bytes from a narrow alphabet (so repeats are common), then enough drain
  // words to flush it and see the done token. A stray push after the first drain is dropped.
  task automatic queue_stream(input int unsigned n, input int unsigned alphabet);
    logic [7:0] base;
    base = $urandom_range(255);
    for (int unsigned i = 0; i < n; i++)
      cmd_q.push_back('{op: OP_PUSH, data: base + 8'($urandom_range(alphabet - 1))});
    for (int unsigned i = 0; i <= n; i++) begin
      cmd_q.push_back('{op: OP_DRAIN, data: 8'($urandom_range(255))});
      if (i == 0 && $urandom_range(7) == 0)
        cmd_q.push_back('{op: OP_PUSH, data: 8'($urandom_range(255))});
    end
  endtask

  task automatic queue_random(input int unsigned words);
    int unsigned target;
    target = cmd_q.size() + words;
    while (cmd_q.size() < target)
      queue_stream($urandom_range(1, 20), $urandom_range(1, 4) == 1 ? 256 :
                   $urandom_range(1, 4));
  endtask

  initial begin
    string lazy_txt;
    hist_cnt = 0;
    pend_cnt = 0;
    wr_ptr = 0;
    defer_next = 1'b0;
    in_drain = 1'b0;
    gain = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: drain on an empty block, a short run of equal bytes, data byte extremes,
    // and a short text run under a lazy gain of zero.
    cmd_q.push_back('{op: OP_DRAIN, data: 8'h00});
    for (int i = 0; i < 6; i++) cmd_q.push_back('{op: OP_PUSH, data: 8'hFF});
    cmd_q.push_back('{op: OP_PUSH, data: 8'h00});
    for (int i = 0; i < 4; i++) cmd_q.push_back('{op: OP_DRAIN, data: 8'hFF});
    cmd_q.push_back('{op: OP_PUSH, data: 8'h55});
    for (int i = 0; i < 4; i++) cmd_q.push_back('{op: OP_DRAIN, data: 8'h00});
    wait_quiet();
    write_gain(9'd0);
    lazy_txt = "abcXbcdabcd";
    foreach (lazy_txt[i])
      cmd_q.push_back('{op: OP_PUSH, data: lazy_txt[i]});
    repeat (12) cmd_q.push_back('{op: OP_DRAIN, data: 8'h00});
    wait_quiet();

    // A run long enough to fill the lookahead: a literal, then a full-length match.
    write_gain(9'd1);
    for (int i = 0; i < LOOKAHEAD + 2; i++) cmd_q.push_back('{op: OP_PUSH, data: 8'hA5});
    repeat (3) cmd_q.push_back('{op: OP_DRAIN, data: 8'h00});
    wait_quiet();

    // Random streams under several lazy gains, the extremes among them.
    write_gain(9'd258);
    queue_random(80);
    wait_quiet();
    write_gain(9'd0);
    queue_random(80);
    wait_quiet();
    write_gain(9'($urandom_range(2, 257)));
    queue_random(70);
    wait_quiet();
    write_gain(9'd1);
    queue_random(80);
    wait_quiet();
    repeat (50) @(posedge clk);

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
